// ===== design/qfk_pkg.sv =====
// qfk_pkg: shared types, constants and multiply-accumulate microcode for the
// quaternion forward kinematics core. No dependencies.
`default_nettype none

package qfk_pkg;

    localparam int MaxJoints = 32;
    localparam int JointIdxW = $clog2(MaxJoints);
    localparam int CountW    = JointIdxW + 1;

    localparam logic [5:0] JointCountReset = 6'd30;

    // mac phase lengths, in products
    localparam int SumSqLen = 4;
    localparam int MatLen   = 24;
    localparam int RotLen   = 9;
    localparam int QmulLen  = 16;
    localparam int MatSize  = 9;

    // normalizer: bits of root and of quotient
    localparam int NormSteps = 17;

    // quaternion component codes
    localparam logic [3:0] QX = 4'd0;
    localparam logic [3:0] QY = 4'd1;
    localparam logic [3:0] QZ = 4'd2;
    localparam logic [3:0] QW = 4'd3;

    typedef logic [3:0][15:0] quat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUMSQ,
        ST_NORM,
        ST_MAT,
        ST_ROT,
        ST_QMUL,
        ST_WRITE,
        ST_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SQRT,
        NS_LOAD,
        NS_DIV,
        NS_DONE
    } norm_state_t;

    typedef struct packed {
        logic       neg;
        logic       dbl;
        logic       first;
        logic       last;
        logic [3:0] dest;
    } mac_ctl_t;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        mac_ctl_t   ctl;
    } uop_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  dest;
        logic [63:0] acc;
    } mac_ret_t;

    function automatic logic signed [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic uop_t mk(logic [3:0] a, logic [3:0] b, logic neg, logic dbl,
                                logic first, logic last, logic [3:0] dest);
        uop_t u;
        u.a_sel     = a;
        u.b_sel     = b;
        u.ctl.neg   = neg;
        u.ctl.dbl   = dbl;
        u.ctl.first = first;
        u.ctl.last  = last;
        u.ctl.dest  = dest;
        return u;
    endfunction

    function automatic uop_t sumsq_uop(logic [4:0] k);
        return mk(k[3:0], k[3:0], 1'b0, 1'b0, k == 5'd0, k == 5'(SumSqLen - 1), 4'd0);
    endfunction

    // rotation matrix entries from the parent quaternion, Q30 before rounding
    function automatic uop_t mat_uop(logic [4:0] k);
        uop_t u;
        case (k)
            5'd0:    u = mk(QX, QX, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0);
            5'd1:    u = mk(QW, QW, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            5'd2:    u = mk(QY, QY, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0);
            5'd3:    u = mk(QZ, QZ, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0);
            5'd4:    u = mk(QX, QY, 1'b0, 1'b1, 1'b1, 1'b0, 4'd1);
            5'd5:    u = mk(QW, QZ, 1'b1, 1'b1, 1'b0, 1'b1, 4'd1);
            5'd6:    u = mk(QX, QZ, 1'b0, 1'b1, 1'b1, 1'b0, 4'd2);
            5'd7:    u = mk(QW, QY, 1'b0, 1'b1, 1'b0, 1'b1, 4'd2);
            5'd8:    u = mk(QW, QZ, 1'b0, 1'b1, 1'b1, 1'b0, 4'd3);
            5'd9:    u = mk(QX, QY, 1'b0, 1'b1, 1'b0, 1'b1, 4'd3);
            5'd10:   u = mk(QW, QW, 1'b0, 1'b0, 1'b1, 1'b0, 4'd4);
            5'd11:   u = mk(QX, QX, 1'b1, 1'b0, 1'b0, 1'b0, 4'd4);
            5'd12:   u = mk(QY, QY, 1'b0, 1'b0, 1'b0, 1'b0, 4'd4);
            5'd13:   u = mk(QZ, QZ, 1'b1, 1'b0, 1'b0, 1'b1, 4'd4);
            5'd14:   u = mk(QW, QX, 1'b1, 1'b1, 1'b1, 1'b0, 4'd5);
            5'd15:   u = mk(QY, QZ, 1'b0, 1'b1, 1'b0, 1'b1, 4'd5);
            5'd16:   u = mk(QW, QY, 1'b1, 1'b1, 1'b1, 1'b0, 4'd6);
            5'd17:   u = mk(QX, QZ, 1'b0, 1'b1, 1'b0, 1'b1, 4'd6);
            5'd18:   u = mk(QW, QX, 1'b0, 1'b1, 1'b1, 1'b0, 4'd7);
            5'd19:   u = mk(QY, QZ, 1'b0, 1'b1, 1'b0, 1'b1, 4'd7);
            5'd20:   u = mk(QW, QW, 1'b0, 1'b0, 1'b1, 1'b0, 4'd8);
            5'd21:   u = mk(QX, QX, 1'b1, 1'b0, 1'b0, 1'b0, 4'd8);
            5'd22:   u = mk(QY, QY, 1'b1, 1'b0, 1'b0, 1'b0, 4'd8);
            5'd23:   u = mk(QZ, QZ, 1'b0, 1'b0, 1'b0, 1'b1, 4'd8);
            default: u = '0;
        endcase
        return u;
    endfunction

    // a_sel: offset component, b_sel: matrix entry, dest: output row
    function automatic uop_t rot_uop(logic [4:0] k);
        uop_t u;
        case (k)
            5'd0:    u = mk(4'd0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0);
            5'd1:    u = mk(4'd1, 4'd1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            5'd2:    u = mk(4'd2, 4'd2, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0);
            5'd3:    u = mk(4'd0, 4'd3, 1'b0, 1'b0, 1'b1, 1'b0, 4'd1);
            5'd4:    u = mk(4'd1, 4'd4, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1);
            5'd5:    u = mk(4'd2, 4'd5, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1);
            5'd6:    u = mk(4'd0, 4'd6, 1'b0, 1'b0, 1'b1, 1'b0, 4'd2);
            5'd7:    u = mk(4'd1, 4'd7, 1'b0, 1'b0, 1'b0, 1'b0, 4'd2);
            5'd8:    u = mk(4'd2, 4'd8, 1'b0, 1'b0, 1'b0, 1'b1, 4'd2);
            default: u = '0;
        endcase
        return u;
    endfunction

    // parent world rotation times normalized local rotation
    function automatic uop_t qmul_uop(logic [4:0] k);
        uop_t u;
        case (k)
            5'd0:    u = mk(QX, QW, 1'b0, 1'b0, 1'b1, 1'b0, QX);
            5'd1:    u = mk(QW, QX, 1'b0, 1'b0, 1'b0, 1'b0, QX);
            5'd2:    u = mk(QY, QZ, 1'b0, 1'b0, 1'b0, 1'b0, QX);
            5'd3:    u = mk(QZ, QY, 1'b1, 1'b0, 1'b0, 1'b1, QX);
            5'd4:    u = mk(QY, QW, 1'b0, 1'b0, 1'b1, 1'b0, QY);
            5'd5:    u = mk(QW, QY, 1'b0, 1'b0, 1'b0, 1'b0, QY);
            5'd6:    u = mk(QZ, QX, 1'b0, 1'b0, 1'b0, 1'b0, QY);
            5'd7:    u = mk(QX, QZ, 1'b1, 1'b0, 1'b0, 1'b1, QY);
            5'd8:    u = mk(QZ, QW, 1'b0, 1'b0, 1'b1, 1'b0, QZ);
            5'd9:    u = mk(QW, QZ, 1'b0, 1'b0, 1'b0, 1'b0, QZ);
            5'd10:   u = mk(QX, QY, 1'b0, 1'b0, 1'b0, 1'b0, QZ);
            5'd11:   u = mk(QY, QX, 1'b1, 1'b0, 1'b0, 1'b1, QZ);
            5'd12:   u = mk(QW, QW, 1'b0, 1'b0, 1'b1, 1'b0, QW);
            5'd13:   u = mk(QX, QX, 1'b1, 1'b0, 1'b0, 1'b0, QW);
            5'd14:   u = mk(QY, QY, 1'b1, 1'b0, 1'b0, 1'b0, QW);
            5'd15:   u = mk(QZ, QZ, 1'b1, 1'b0, 1'b0, 1'b1, QW);
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== design/quaternion_forward_kinematics_core.sv =====
// quaternion_forward_kinematics_core: top level; joint sequencer, joint stores
// and result register. Depends on qfk_pkg, qfk_mac and qfk_norm.
//
//  channel | signals                               | transfer when
//  --------+---------------------------------------+----------------------
//  cfg     | cfg_valid cfg_ready joint_count       | cfg_valid & cfg_ready
//  in      | in_valid in_stall rot_* parent_index  | in_valid & !in_stall
//          | bone_* base_*                         |
//  out     | out_valid out_stall world_* joint_*   | out_valid & !out_stall
//          | frame_end forward_parent              |
//
// One joint at a time. A root skips the matrix, rotation and product phases;
// a zero-length quaternion skips the square root and the divides. The
// normalizer (17-step root, then one divide per component), the single
// multiplier (53 products for a child) and any output stall set the joint time.
// Reset clears the joint counter, the store valid bits and all control; no
// clearing pass. in_stall is high from a transfer until its result is taken.
`default_nettype none

module quaternion_forward_kinematics_core (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         joint_count,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] rot_x,
    input  wire logic signed [15:0] rot_y,
    input  wire logic signed [15:0] rot_z,
    input  wire logic signed [15:0] rot_w,
    input  wire logic signed [5:0]  parent_index,
    input  wire logic signed [31:0] bone_x,
    input  wire logic signed [31:0] bone_y,
    input  wire logic signed [31:0] bone_z,
    input  wire logic signed [31:0] base_x,
    input  wire logic signed [31:0] base_y,
    input  wire logic signed [31:0] base_z,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      world_x,
    output logic signed [31:0]      world_y,
    output logic signed [31:0]      world_z,
    output logic [4:0]              joint_number,
    output logic                    frame_end,
    output logic                    forward_parent
);

    localparam int IdxW   = qfk_pkg::JointIdxW;
    localparam int CntW   = qfk_pkg::CountW;
    localparam int EntryW = 160;

    qfk_pkg::top_state_t state_reg, state_next;
    logic [4:0]          step_reg, step_next;

    logic [5:0]          joint_count_reg;
    logic [IdxW-1:0]     counter_reg;
    logic [qfk_pkg::MaxJoints-1:0] valid_reg;
    logic                rdv_reg;

    logic [EntryW-1:0]   mem [qfk_pkg::MaxJoints];
    logic [EntryW-1:0]   rd_reg;

    qfk_pkg::quat_t      loc_reg;
    qfk_pkg::quat_t      nq_reg;
    qfk_pkg::quat_t      wq_reg;
    logic [2:0][31:0]    bone_reg;
    logic [2:0][31:0]    base_reg;
    logic [2:0][31:0]    pos_reg;
    logic [31:0]         m_reg [qfk_pkg::MatSize];
    logic                root_reg;
    logic                fwd_reg;
    logic [IdxW-1:0]     jnum_reg;
    logic                fend_reg;

    logic                accept;
    logic [CntW-1:0]     cnt_eff;
    logic [IdxW-1:0]     j_cur;
    logic [CntW-1:0]     j_inc;
    logic [IdxW-1:0]     p_addr;
    logic                p_root;

    qfk_pkg::uop_t       uop;
    logic                mac_issue;
    logic signed [31:0]  op_a;
    logic signed [31:0]  op_b;
    qfk_pkg::mac_ret_t   ret;
    logic signed [63:0]  acc;

    logic                norm_start;
    logic                norm_done;
    qfk_pkg::quat_t      norm_q;

    qfk_pkg::quat_t      par_q;
    logic [2:0][31:0]    par_pos;

    logic signed [63:0]  m_rnd;
    logic signed [63:0]  q_rnd;
    logic [15:0]         q_sat;
    logic signed [63:0]  o_rnd;
    logic signed [63:0]  pos_sum;
    logic [31:0]         pos_sat;
    logic [31:0]         pp_sel;
    logic [31:0]         bone_sel;
    logic [31:0]         m_sel;

    assign accept = in_valid && !in_stall;

    // joint bookkeeping
    always_comb
    begin
        if (joint_count_reg == 6'd0)
        begin
            cnt_eff = CntW'(1);
        end
        else if (CntW'(joint_count_reg) > CntW'(qfk_pkg::MaxJoints))
        begin
            cnt_eff = CntW'(qfk_pkg::MaxJoints);
        end
        else
        begin
            cnt_eff = CntW'(joint_count_reg);
        end
        j_cur  = ({1'b0, counter_reg} >= cnt_eff) ? '0 : counter_reg;
        j_inc  = {1'b0, j_cur} + CntW'(1);
        p_addr = parent_index[IdxW-1:0];
        p_root = parent_index[5] || ({1'b0, p_addr} >= cnt_eff);
    end

    // parent entry, zero until written
    always_comb
    begin
        par_q      = rdv_reg ? rd_reg[159:96] : '0;
        par_pos[0] = rdv_reg ? rd_reg[95:64]  : '0;
        par_pos[1] = rdv_reg ? rd_reg[63:32]  : '0;
        par_pos[2] = rdv_reg ? rd_reg[31:0]   : '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            qfk_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = qfk_pkg::ST_SUMSQ;
                    step_next  = '0;
                end
            end
            qfk_pkg::ST_SUMSQ:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(qfk_pkg::SumSqLen))
                begin
                    state_next = qfk_pkg::ST_NORM;
                    step_next  = '0;
                end
            end
            qfk_pkg::ST_NORM:
            begin
                if (norm_done)
                begin
                    state_next = root_reg ? qfk_pkg::ST_WRITE : qfk_pkg::ST_MAT;
                end
            end
            qfk_pkg::ST_MAT:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(qfk_pkg::MatLen))
                begin
                    state_next = qfk_pkg::ST_ROT;
                    step_next  = '0;
                end
            end
            qfk_pkg::ST_ROT:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(qfk_pkg::RotLen))
                begin
                    state_next = qfk_pkg::ST_QMUL;
                    step_next  = '0;
                end
            end
            qfk_pkg::ST_QMUL:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(qfk_pkg::QmulLen))
                begin
                    state_next = qfk_pkg::ST_WRITE;
                    step_next  = '0;
                end
            end
            qfk_pkg::ST_WRITE:
            begin
                state_next = qfk_pkg::ST_OUT;
            end
            qfk_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = qfk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qfk_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and mac control
    always_comb
    begin
        cfg_ready  = 1'b1;
        in_stall   = state_reg != qfk_pkg::ST_IDLE;
        out_valid  = state_reg == qfk_pkg::ST_OUT;
        norm_start = (state_reg == qfk_pkg::ST_SUMSQ)
                     && (step_reg == 5'(qfk_pkg::SumSqLen));
        uop        = '0;
        mac_issue  = 1'b0;
        case (state_reg)
            qfk_pkg::ST_SUMSQ:
            begin
                uop       = qfk_pkg::sumsq_uop(step_reg);
                mac_issue = step_reg < 5'(qfk_pkg::SumSqLen);
            end
            qfk_pkg::ST_MAT:
            begin
                uop       = qfk_pkg::mat_uop(step_reg);
                mac_issue = step_reg < 5'(qfk_pkg::MatLen);
            end
            qfk_pkg::ST_ROT:
            begin
                uop       = qfk_pkg::rot_uop(step_reg);
                mac_issue = step_reg < 5'(qfk_pkg::RotLen);
            end
            qfk_pkg::ST_QMUL:
            begin
                uop       = qfk_pkg::qmul_uop(step_reg);
                mac_issue = step_reg < 5'(qfk_pkg::QmulLen);
            end
            default:
            begin
            end
        endcase
    end

    // multiplier operands
    always_comb
    begin
        bone_sel = (uop.a_sel[1:0] == 2'd3) ? '0 : bone_reg[uop.a_sel[1:0]];
        m_sel    = (uop.b_sel < 4'(qfk_pkg::MatSize)) ? m_reg[uop.b_sel] : '0;
        op_a     = '0;
        op_b     = '0;
        case (state_reg)
            qfk_pkg::ST_SUMSQ:
            begin
                op_a = qfk_pkg::sx16(loc_reg[uop.a_sel[1:0]]);
                op_b = qfk_pkg::sx16(loc_reg[uop.b_sel[1:0]]);
            end
            qfk_pkg::ST_MAT:
            begin
                op_a = qfk_pkg::sx16(par_q[uop.a_sel[1:0]]);
                op_b = qfk_pkg::sx16(par_q[uop.b_sel[1:0]]);
            end
            qfk_pkg::ST_ROT:
            begin
                op_a = $signed(bone_sel);
                op_b = $signed(m_sel);
            end
            qfk_pkg::ST_QMUL:
            begin
                op_a = qfk_pkg::sx16(par_q[uop.a_sel[1:0]]);
                op_b = qfk_pkg::sx16(nq_reg[uop.b_sel[1:0]]);
            end
            default:
            begin
            end
        endcase
    end

    qfk_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (mac_issue),
        .op_a  (op_a),
        .op_b  (op_b),
        .ctl   (uop.ctl),
        .ret   (ret)
    );

    qfk_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .sum_sq (ret.acc[32:0]),
        .q_in   (loc_reg),
        .done   (norm_done),
        .q_out  (norm_q)
    );

    // rounding of retired sums
    always_comb
    begin
        acc     = $signed(ret.acc);
        m_rnd   = (acc + 64'sd2) >>> 2;
        q_rnd   = (acc + 64'sd16384) >>> 15;
        if (q_rnd > 64'sd32767)
        begin
            q_sat = 16'h7fff;
        end
        else if (q_rnd < -64'sd32768)
        begin
            q_sat = 16'h8000;
        end
        else
        begin
            q_sat = q_rnd[15:0];
        end
        pp_sel  = (ret.dest[1:0] == 2'd3) ? '0 : par_pos[ret.dest[1:0]];
        o_rnd   = (acc + (64'sd1 <<< 27)) >>> 28;
        pos_sum = {{32{pp_sel[31]}}, pp_sel} + o_rnd;
        if (pos_sum > 64'sd2147483647)
        begin
            pos_sat = 32'h7fff_ffff;
        end
        else if (pos_sum < -64'sd2147483648)
        begin
            pos_sat = 32'h8000_0000;
        end
        else
        begin
            pos_sat = pos_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= qfk_pkg::ST_IDLE;
            step_reg        <= '0;
            joint_count_reg <= qfk_pkg::JointCountReset;
            counter_reg     <= '0;
            valid_reg       <= '0;
            rdv_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready)
            begin
                joint_count_reg <= joint_count;
            end
            if (accept)
            begin
                counter_reg <= (j_inc >= cnt_eff) ? '0 : j_inc[IdxW-1:0];
                rdv_reg     <= valid_reg[p_addr];
            end
            if (state_reg == qfk_pkg::ST_WRITE)
            begin
                valid_reg[jnum_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            loc_reg     <= {rot_w, rot_z, rot_y, rot_x};
            bone_reg    <= {bone_z, bone_y, bone_x};
            base_reg    <= {base_z, base_y, base_x};
            root_reg    <= p_root;
            fwd_reg     <= !p_root && (p_addr >= j_cur);
            jnum_reg    <= j_cur;
            fend_reg    <= j_inc == cnt_eff;
            rd_reg      <= mem[p_addr];
        end
        if (norm_done)
        begin
            nq_reg <= norm_q;
            if (root_reg)
            begin
                wq_reg  <= norm_q;
                pos_reg <= base_reg;
            end
        end
        if (ret.valid)
        begin
            case (state_reg)
                qfk_pkg::ST_MAT:
                begin
                    if (ret.dest < 4'(qfk_pkg::MatSize))
                    begin
                        m_reg[ret.dest] <= m_rnd[31:0];
                    end
                end
                qfk_pkg::ST_ROT:
                begin
                    if (ret.dest[1:0] != 2'd3)
                    begin
                        pos_reg[ret.dest[1:0]] <= pos_sat;
                    end
                end
                qfk_pkg::ST_QMUL:
                begin
                    wq_reg[ret.dest[1:0]] <= q_sat;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == qfk_pkg::ST_WRITE)
        begin
            mem[jnum_reg] <= {wq_reg, pos_reg[0], pos_reg[1], pos_reg[2]};
        end
    end

    assign world_x        = $signed(pos_reg[0]);
    assign world_y        = $signed(pos_reg[1]);
    assign world_z        = $signed(pos_reg[2]);
    assign joint_number   = jnum_reg;
    assign frame_end      = fend_reg;
    assign forward_parent = fwd_reg;

endmodule

`default_nettype wire

// ===== design/qfk_mac.sv =====
// qfk_mac: shared 32x32 signed multiplier with a registered product and a
// 64-bit accumulator. Depends on qfk_pkg.
`default_nettype none

module qfk_mac (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  issue,
    input  wire logic signed [31:0]    op_a,
    input  wire logic signed [31:0]    op_b,
    input  wire qfk_pkg::mac_ctl_t     ctl,
    output qfk_pkg::mac_ret_t          ret
);

    logic                 pend_reg;
    logic signed [63:0]   prod_reg;
    qfk_pkg::mac_ctl_t    ctl_reg;
    logic signed [63:0]   acc_reg;
    logic signed [63:0]   term;
    logic signed [63:0]   acc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= op_a * op_b;
            ctl_reg  <= ctl;
        end
        if (pend_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    always_comb
    begin
        term = ctl_reg.dbl ? (prod_reg <<< 1) : prod_reg;
        if (ctl_reg.neg)
        begin
            term = -term;
        end
        acc_sum = (ctl_reg.first ? 64'sd0 : acc_reg) + term;
    end

    always_comb
    begin
        ret.valid = pend_reg && ctl_reg.last;
        ret.dest  = ctl_reg.dest;
        ret.acc   = acc_sum;
    end

endmodule

`default_nettype wire

// ===== design/qfk_norm.sv =====
// qfk_norm: quaternion normalizer; bit-serial square root of the sum of squares,
// then one restoring divide per component. Depends on qfk_pkg.
`default_nettype none

module qfk_norm (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [32:0]       sum_sq,
    input  wire qfk_pkg::quat_t    q_in,
    output logic                   done,
    output qfk_pkg::quat_t         q_out
);

    qfk_pkg::norm_state_t state_reg, state_next;

    logic [4:0]      it_reg;
    logic [1:0]      comp_reg;
    logic [33:0]     srem_reg;
    logic [33:0]     root_reg;
    logic [33:0]     bit_reg;
    logic [17:0]     rem_reg;
    logic [31:0]     num_reg;
    logic [16:0]     quot_reg;
    qfk_pkg::quat_t  q_reg;
    qfk_pkg::quat_t  res_reg;

    logic [33:0]     trial;
    logic            sq_ge;
    logic [16:0]     len;
    logic [17:0]     divisor;
    logic [15:0]     comp_val;
    logic [15:0]     comp_abs;
    logic [31:0]     num_init;
    logic [18:0]     rem_sh;
    logic            div_ge;
    logic [18:0]     rem_sub;
    logic [16:0]     quot_new;
    logic [16:0]     quot_neg;
    logic [15:0]     comp_res;
    logic            last_it;

    always_comb
    begin
        trial    = root_reg + bit_reg;
        sq_ge    = srem_reg >= trial;
        len      = root_reg[16:0];
        divisor  = {len, 1'b0};
        comp_val = q_reg[comp_reg];
        comp_abs = comp_val[15] ? (~comp_val + 16'd1) : comp_val;
        num_init = {comp_abs, 16'd0} + {15'd0, len};
        rem_sh   = {rem_reg, num_reg[31]};
        div_ge   = rem_sh >= {1'b0, divisor};
        rem_sub  = rem_sh - {1'b0, divisor};
        quot_new = {quot_reg[15:0], div_ge};
        quot_neg = ~quot_new + 17'd1;
        if (comp_val[15])
        begin
            comp_res = quot_neg[15:0];
        end
        else if (quot_new > 17'd32767)
        begin
            comp_res = 16'h7fff;
        end
        else
        begin
            comp_res = quot_new[15:0];
        end
        last_it = it_reg == 5'(qfk_pkg::NormSteps - 1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qfk_pkg::NS_IDLE:
            begin
                if (start)
                begin
                    state_next = (sum_sq == 33'd0) ? qfk_pkg::NS_DONE : qfk_pkg::NS_SQRT;
                end
            end
            qfk_pkg::NS_SQRT:
            begin
                if (last_it)
                begin
                    state_next = qfk_pkg::NS_LOAD;
                end
            end
            qfk_pkg::NS_LOAD:
            begin
                state_next = qfk_pkg::NS_DIV;
            end
            qfk_pkg::NS_DIV:
            begin
                if (last_it)
                begin
                    state_next = (comp_reg == 2'd3) ? qfk_pkg::NS_DONE : qfk_pkg::NS_LOAD;
                end
            end
            qfk_pkg::NS_DONE:
            begin
                state_next = qfk_pkg::NS_IDLE;
            end
            default:
            begin
                state_next = qfk_pkg::NS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done  = state_reg == qfk_pkg::NS_DONE;
        q_out = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qfk_pkg::NS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            qfk_pkg::NS_IDLE:
            begin
                q_reg    <= q_in;
                res_reg  <= q_in;
                srem_reg <= {1'b0, sum_sq};
                root_reg <= '0;
                bit_reg  <= 34'd1 << 32;
                it_reg   <= '0;
                comp_reg <= '0;
            end
            qfk_pkg::NS_SQRT:
            begin
                if (sq_ge)
                begin
                    srem_reg <= srem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                it_reg  <= last_it ? 5'd0 : it_reg + 5'd1;
            end
            qfk_pkg::NS_LOAD:
            begin
                rem_reg  <= 18'(num_init[31:17]);
                num_reg  <= num_init << 15;
                quot_reg <= '0;
                it_reg   <= '0;
            end
            qfk_pkg::NS_DIV:
            begin
                rem_reg  <= div_ge ? rem_sub[17:0] : rem_sh[17:0];
                num_reg  <= num_reg << 1;
                quot_reg <= quot_new;
                it_reg   <= it_reg + 5'd1;
                if (last_it)
                begin
                    res_reg[comp_reg] <= comp_res;
                    comp_reg          <= comp_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/quaternion_forward_kinematics_core_tb.sv =====
// Testbench for quaternion_forward_kinematics_core: directed and random joint frames,
// checked against an in-bench fixed-point predictor of the joint hierarchy.
// Depends on qfk_pkg and the core RTL.
`timescale 1ns / 1ps

module quaternion_forward_kinematics_core_tb;

    typedef struct {
        shortint x;
        shortint y;
        shortint z;
        shortint w;
    } q15_t;

    typedef struct {
        int      wx;
        int      wy;
        int      wz;
        bit [4:0] jn;
        bit      fend;
        bit      fwd;
    } joint_pos_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [5:0]         joint_count = 6'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] rot_x = '0, rot_y = '0, rot_z = '0, rot_w = '0;
    logic signed [5:0]  parent_index = '0;
    logic signed [31:0] bone_x = '0, bone_y = '0, bone_z = '0;
    logic signed [31:0] base_x = '0, base_y = '0, base_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] world_x, world_y, world_z;
    logic [4:0]         joint_number;
    logic               frame_end;
    logic               forward_parent;

    quaternion_forward_kinematics_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .joint_count(joint_count),
        .in_valid(in_valid), .in_stall(in_stall),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .rot_w(rot_w),
        .parent_index(parent_index),
        .bone_x(bone_x), .bone_y(bone_y), .bone_z(bone_z),
        .base_x(base_x), .base_y(base_y), .base_z(base_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .joint_number(joint_number), .frame_end(frame_end),
        .forward_parent(forward_parent)
    );

    always #10 clk = ~clk;

    // predictor state
    int unsigned model_count = 30;
    int unsigned model_counter = 0;
    q15_t        rot_store[qfk_pkg::MaxJoints];
    int          pos_x[qfk_pkg::MaxJoints];
    int          pos_y[qfk_pkg::MaxJoints];
    int          pos_z[qfk_pkg::MaxJoints];

    joint_pos_t  expected_pos[$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          hold_cycles = 0;
    bit          no_idle = 1'b0;

    function automatic longint round_sh(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic shortint clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return shortint'(v);
    endfunction

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic longint int_sqrt(longint s);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > s) b = b >>> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >>> 1) + b;
            end
            else
            begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic shortint unit_comp(shortint c, longint len);
        longint a;
        longint n;
        a = (c < 0) ? -longint'(c) : longint'(c);
        n = (a * 65536 + len) / (2 * len);
        return clip16((c < 0) ? -n : n);
    endfunction

    function automatic q15_t unit_quat(q15_t q);
        longint s;
        longint len;
        q15_t   r;
        s = longint'(q.x) * q.x + longint'(q.y) * q.y + longint'(q.z) * q.z
            + longint'(q.w) * q.w;
        if (s == 0) return q;
        len = int_sqrt(s);
        r.x = unit_comp(q.x, len);
        r.y = unit_comp(q.y, len);
        r.z = unit_comp(q.z, len);
        r.w = unit_comp(q.w, len);
        return r;
    endfunction

    function automatic q15_t quat_product(q15_t a, q15_t b);
        longint ax, ay, az, aw, bx, by, bz, bw;
        q15_t   r;
        ax = a.x; ay = a.y; az = a.z; aw = a.w;
        bx = b.x; by = b.y; bz = b.z; bw = b.w;
        r.x = clip16(round_sh(ax * bw + aw * bx + ay * bz - az * by, 15));
        r.y = clip16(round_sh(ay * bw + aw * by + az * bx - ax * bz, 15));
        r.z = clip16(round_sh(az * bw + aw * bz + ax * by - ay * bx, 15));
        r.w = clip16(round_sh(aw * bw - ax * bx - ay * by - az * bz, 15));
        return r;
    endfunction

    // joint world position and stores update for one accepted joint
    task automatic predict_joint();
        longint    p, x, y, z, w, px, py, pz;
        longint    m[9];
        longint    v[3];
        longint    o[3];
        q15_t      loc;
        q15_t      pr;
        int unsigned cnt, j;
        joint_pos_t e;
        cnt = model_count;
        if (cnt < 1) cnt = 1;
        if (cnt > qfk_pkg::MaxJoints) cnt = qfk_pkg::MaxJoints;
        if (model_counter >= cnt) model_counter = 0;
        j = model_counter;
        p = parent_index;
        loc.x = rot_x; loc.y = rot_y; loc.z = rot_z; loc.w = rot_w;
        loc = unit_quat(loc);
        e.fwd = 1'b0;
        if (p < 0 || p >= cnt)
        begin
            px = base_x; py = base_y; pz = base_z;
            rot_store[j] = loc;
        end
        else
        begin
            pr = rot_store[p];
            e.fwd = (p >= j);
            x = pr.x; y = pr.y; z = pr.z; w = pr.w;
            m[0] = x * x + w * w - y * y - z * z;
            m[1] = 2 * x * y - 2 * w * z;
            m[2] = 2 * x * z + 2 * w * y;
            m[3] = 2 * w * z + 2 * x * y;
            m[4] = w * w - x * x + y * y - z * z;
            m[5] = -2 * w * x + 2 * y * z;
            m[6] = -2 * w * y + 2 * x * z;
            m[7] = 2 * w * x + 2 * y * z;
            m[8] = w * w - x * x - y * y + z * z;
            for (int i = 0; i < 9; i++) m[i] = round_sh(m[i], 2);
            v[0] = bone_x; v[1] = bone_y; v[2] = bone_z;
            for (int i = 0; i < 3; i++)
                o[i] = round_sh(v[0] * m[3*i] + v[1] * m[3*i+1] + v[2] * m[3*i+2], 28);
            px = clip32(longint'(pos_x[p]) + o[0]);
            py = clip32(longint'(pos_y[p]) + o[1]);
            pz = clip32(longint'(pos_z[p]) + o[2]);
            rot_store[j] = quat_product(pr, loc);
        end
        pos_x[j] = int'(px);
        pos_y[j] = int'(py);
        pos_z[j] = int'(pz);
        e.wx = int'(px);
        e.wy = int'(py);
        e.wz = int'(pz);
        e.jn = j[4:0];
        e.fend = (j + 1 == cnt);
        expected_pos.push_back(e);
        model_counter = (j + 1 >= cnt) ? 0 : j + 1;
    endtask

    task automatic send_joint(shortint qx, shortint qy, shortint qz, shortint qw,
                              int par, int bx, int by, int bz,
                              int ox, int oy, int oz);
        int gap;
        @(negedge clk);
        if (!no_idle)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
        end
        rot_x = qx; rot_y = qy; rot_z = qz; rot_w = qw;
        parent_index = par[5:0];
        bone_x = bx; bone_y = by; bone_z = bz;
        base_x = ox; base_y = oy; base_z = oz;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        predict_joint();
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_pos.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_joint_count(logic [5:0] n);
        drain_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        joint_count = n;
        do @(posedge clk); while (!cfg_ready);
        model_count = n;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int rand_pos();
        if ($urandom_range(0, 7) == 0) return $urandom();
        return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
    endfunction

    function automatic shortint rand_comp();
        if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
        return shortint'($urandom());
    endfunction

    task automatic send_random_joint();
        int      par;
        int unsigned j;
        int unsigned cnt;
        shortint q[4];
        cnt = (model_count < 1) ? 1 :
              (model_count > qfk_pkg::MaxJoints ? qfk_pkg::MaxJoints : model_count);
        j = (model_counter >= cnt) ? 0 : model_counter;
        case ($urandom_range(0, 9))
            0:       par = -$urandom_range(1, 32);
            1:       par = $urandom_range(j, 31);
            2:       par = $urandom_range(0, 63) - 32;
            default: par = (j == 0) ? -1 : $urandom_range(0, j - 1);
        endcase
        foreach (q[i]) q[i] = rand_comp();
        if ($urandom_range(0, 30) == 0) q = '{0, 0, 0, 0};
        send_joint(q[0], q[1], q[2], q[3], par, rand_pos(), rand_pos(), rand_pos(),
                   rand_pos(), rand_pos(), rand_pos());
    endtask

    task automatic test_roots();
        write_joint_count(6'd30);
        send_joint(0, 0, 0, 16'sh7fff, -1, 0, 0, 0,
                   32'sh7fffffff, 32'sh80000000, 0);
        send_joint(0, 0, 0, 0, -32, 5, 5, 5, 32'sh80000000, 32'sh7fffffff, -1);
        send_joint(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 31, 0, 0, 0,
                   1, 2, 3);
        send_joint(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 30, 0, 0, 0,
                   -1, -1, -1);
    endtask

    task automatic test_children();
        send_joint(100, -200, 300, 4000, 0, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh7fffffff, 0, 0, 0);
        send_joint(1, 0, 0, 0, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                   0, 0, 0);
        send_joint(0, 0, 0, 0, 2, 32'h00010000, -32'sh20000, 32'h00030000, 0, 0, 0);
        send_joint(-16'sh8000, 0, 0, 0, 3, 32'h00010000, 32'h00010000, 0, 0, 0, 0);
    endtask

    task automatic test_forward_parent();
        send_joint(0, 16'sh4000, 0, 16'sh4000, 8, 32'h10000, 0, 0, 0, 0, 0);
        send_joint(0, 0, 16'sh2000, 16'sh6000, 9, 0, 32'h10000, 0, 0, 0, 0);
        send_joint(0, 0, 0, 16'sh7fff, 29, 0, 0, 32'h10000, 0, 0, 0);
    endtask

    task automatic test_count_extremes();
        write_joint_count(6'd1);
        send_joint(0, 0, 0, 16'sh7fff, 0, 7, 7, 7, 9, 9, 9);
        send_joint(0, 0, 0, 16'sh7fff, -1, 7, 7, 7, 9, 9, 9);
        write_joint_count(6'd0);
        send_joint(3, 3, 3, 3, 0, 32'h10000, 0, 0, 1, 1, 1);
        write_joint_count(6'd63);
        for (int i = 0; i < 4; i++) send_random_joint();
        write_joint_count(6'd32);
        send_joint(0, 0, 0, 16'sh7fff, 31, 1, 1, 1, 2, 2, 2);
        send_joint(0, 0, 0, 16'sh7fff, 0, 1, 1, 1, 2, 2, 2);
    endtask

    task automatic test_backpressure();
        no_idle = 1'b1;
        @(negedge clk);
        hold_cycles = 600;
        for (int i = 0; i < 12; i++) send_random_joint();
        no_idle = 1'b0;
        drain_results();
        for (int i = 0; i < 8; i++) send_random_joint();
    endtask

    task automatic test_random_frames();
        logic [5:0] counts[8] = '{6'd30, 6'd1, 6'd32, 6'd5, 6'd0, 6'd63, 6'd17, 6'd2};
        foreach (counts[k])
        begin
            write_joint_count(counts[k]);
            for (int i = 0; i < 170; i++) send_random_joint();
        end
    endtask

    // receiver: long hold-offs on request, else no stall, light or heavy random stalls
    always @(negedge clk)
    begin
        int mode;
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            mode = ($time / 200000) % 3;
            if (mode == 0) out_stall <= 1'b0;
            else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
            else out_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        joint_pos_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pos.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: joint %0d pos %0d %0d %0d",
                             joint_number, world_x, world_y, world_z);
            end
            else
            begin
                e = expected_pos.pop_front();
                if (world_x !== e.wx || world_y !== e.wy || world_z !== e.wz ||
                    joint_number !== e.jn || frame_end !== e.fend ||
                    forward_parent !== e.fwd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp %0d %0d %0d j%0d e%0d f%0d, ",
                                  "got %0d %0d %0d j%0d e%0d f%0d"},
                                 e.wx, e.wy, e.wz, e.jn, e.fend, e.fwd,
                                 world_x, world_y, world_z, joint_number,
                                 frame_end, forward_parent);
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        foreach (rot_store[i])
        begin
            rot_store[i] = '{0, 0, 0, 0};
            pos_x[i] = 0;
            pos_y[i] = 0;
            pos_z[i] = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_roots();
        test_children();
        test_forward_parent();
        test_count_extremes();
        test_backpressure();
        test_random_frames();
        drain_results();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_pos.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qfk_pkg.sv
design/qfk_mac.sv
design/qfk_norm.sv
design/quaternion_forward_kinematics_core.sv
tb/quaternion_forward_kinematics_core_tb.sv
